// ===== hw/rtl/dbst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-band scan threshold engine: shared package
// Field widths, register indexes, fixed constants and the structs that pass
// between the sequencer, the register bank and the serial arithmetic unit.
// ----------------------------------------------------------------------------
package dbst_pkg;

  // Field widths
  localparam int LVL_W  = 8;    // RSSI and threshold fields
  localparam int ENT_W  = 16;   // table entries and the result
  localparam int EXT_W  = 10;   // widened level arithmetic
  localparam int NT_W   = 11;   // stepped trigger, span and divisor arithmetic
  localparam int MAG_W  = 16;   // |entry - switch|
  localparam int SPAN_W = 8;    // |high - new trigger|
  localparam int DEN_W  = 8;    // |high - switch|
  localparam int PROD_W = 23;   // product magnitude, then quotient magnitude

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int APB_DW = 32;

  // Fixed rule constants
  localparam int ADJ_GAP   = 10;
  localparam int ADJ_STEP  = 5;
  localparam int DELTA_LIM = 5;
  localparam int TRIG_STEP = 5;
  localparam int TRIG_OVF  = 10;

  typedef enum logic [2:0] {
    REG_SAME_ROUTER = 3'd0,
    REG_PEAK_24G    = 3'd1,
    REG_PARTNER_24G = 3'd2,
    REG_PEAK_5G     = 3'd3,
    REG_OWN_5G      = 3'd4,
    REG_PEAK_SCAN   = 3'd5,
    REG_LEAST_TGT   = 3'd6
  } reg_idx_t;

  typedef enum logic {
    ACT_QUERY  = 1'b0,
    ACT_UPDATE = 1'b1
  } action_t;

  typedef struct packed {
    logic                    same_router;
    logic signed [LVL_W-1:0] peak_24g;
    logic signed [LVL_W-1:0] partner_24g;
    logic signed [LVL_W-1:0] peak_5g;
    logic signed [LVL_W-1:0] own_5g;
    logic signed [LVL_W-1:0] peak_scan;
    logic signed [LVL_W-1:0] least_tgt;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  mcand;
    logic [SPAN_W-1:0] mplier;
    logic [DEN_W-1:0]  divisor;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } md_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dbst_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-band scan threshold engine: channel interfaces
// Request channel (command in) and level channel (result out), valid/ready.
// ----------------------------------------------------------------------------
interface dbst_cmd_if import dbst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [LVL_W-1:0] switch_level;
  logic signed [LVL_W-1:0] trigger_level;
  logic signed [LVL_W-1:0] rssi_24g_now;
  logic signed [LVL_W-1:0] rssi_5g_now;

  modport source (output valid, action, switch_level, trigger_level, rssi_24g_now,
                  rssi_5g_now, input ready);
  modport sink   (input valid, action, switch_level, trigger_level, rssi_24g_now,
                  rssi_5g_now, output ready);
endinterface

interface dbst_lvl_if import dbst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ENT_W-1:0] scan_level;

  modport source (output valid, scan_level, input ready);
  modport sink   (input valid, scan_level, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dbst_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-band scan threshold engine: configuration register bank
// APB-style write/read access to the router flag and the learned RSSI levels.
// ----------------------------------------------------------------------------
module dbst_cfg_regs import dbst_pkg::*; #(
  parameter int INVALID_LEVEL = -127
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  localparam logic [LVL_W-1:0] INV_L = LVL_W'(INVALID_LEVEL);

  logic     wr_en;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_idx_t'(paddr[4:2]);

  // Write the addressed register at the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.same_router <= 1'b0;
      cfg.peak_24g    <= INV_L;
      cfg.partner_24g <= INV_L;
      cfg.peak_5g     <= INV_L;
      cfg.own_5g      <= INV_L;
      cfg.peak_scan   <= INV_L;
      cfg.least_tgt   <= INV_L;
    end else if (wr_en) begin
      case (sel)
        REG_SAME_ROUTER: cfg.same_router <= pwdata[0];
        REG_PEAK_24G:    cfg.peak_24g    <= pwdata[LVL_W-1:0];
        REG_PARTNER_24G: cfg.partner_24g <= pwdata[LVL_W-1:0];
        REG_PEAK_5G:     cfg.peak_5g     <= pwdata[LVL_W-1:0];
        REG_OWN_5G:      cfg.own_5g      <= pwdata[LVL_W-1:0];
        REG_PEAK_SCAN:   cfg.peak_scan   <= pwdata[LVL_W-1:0];
        REG_LEAST_TGT:   cfg.least_tgt   <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (sel)
      REG_SAME_ROUTER: prdata[0]         = cfg.same_router;
      REG_PEAK_24G:    prdata[LVL_W-1:0] = cfg.peak_24g;
      REG_PARTNER_24G: prdata[LVL_W-1:0] = cfg.partner_24g;
      REG_PEAK_5G:     prdata[LVL_W-1:0] = cfg.peak_5g;
      REG_OWN_5G:      prdata[LVL_W-1:0] = cfg.own_5g;
      REG_PEAK_SCAN:   prdata[LVL_W-1:0] = cfg.peak_scan;
      REG_LEAST_TGT:   prdata[LVL_W-1:0] = cfg.least_tgt;
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dbst_serial_md.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-band scan threshold engine: serial multiply-divide unit
// Unsigned shift-add multiply, one multiplier bit per cycle, followed by a
// restoring divide, one quotient bit per cycle, in the same shift register.
// ----------------------------------------------------------------------------
module dbst_serial_md import dbst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

  localparam int CNT_W = $clog2(PROD_W + 1);

  md_state_t         state;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] mcand_sh;
  logic [SPAN_W-1:0] mplier_sh;
  logic [PROD_W-1:0] acc;
  logic [DEN_W-1:0]  divisor;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    rem_sh;
  logic              sub_ok;

  // Next partial remainder: bring down the top bit of the dividend
  assign rem_sh = {rem, acc[PROD_W-1]};
  assign sub_ok = rem_sh >= {1'b0, divisor};

  // Sequence the multiply steps, then the divide steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        MD_IDLE: if (req.start) state <= MD_MUL;
        MD_MUL:  if (cnt == '0) state <= MD_DIV;
        MD_DIV: begin
          if (cnt == '0) begin
            state <= MD_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

  // Shift-add and shift-subtract datapath
  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        mcand_sh  <= PROD_W'(req.mcand);
        mplier_sh <= req.mplier;
        divisor   <= req.divisor;
        acc       <= '0;
        rem       <= '0;
        cnt       <= CNT_W'(SPAN_W - 1);
      end
      MD_MUL: begin
        if (mplier_sh[0]) acc <= acc + mcand_sh;
        mcand_sh  <= {mcand_sh[PROD_W-2:0], 1'b0};
        mplier_sh <= {1'b0, mplier_sh[SPAN_W-1:1]};
        cnt       <= (cnt == '0) ? CNT_W'(PROD_W - 1) : cnt - 1'b1;
      end
      MD_DIV: begin
        if (sub_ok) begin
          rem <= DEN_W'(rem_sh - {1'b0, divisor});
          acc <= {acc[PROD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DEN_W-1:0];
          acc <= {acc[PROD_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.quot = acc;

endmodule
`default_nettype wire

// ===== hw/rtl/dual_band_scan_threshold_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-band scan threshold engine
// Picks the trigger scan level for a switch level and rescales the per-level
// threshold table on update requests.
// ----------------------------------------------------------------------------
// Usage:
//  cmd   : request channel (valid/ready). action 0 queries the scan level for
//          switch_level, action 1 steps the trigger level and rescales the
//          table, then answers the table entry for switch_level.
//  level : one scan_level per request, held in an output register.
//  APB   : router flag and learned RSSI levels. The user must see that they
//          are written only while idle; the block itself has no check for it.
// Rescale: an update that rescales the table runs each of its 61 entries
//  through the serial unit with 8 multiply steps and 23 divide steps.
//  One request is in flight at a time; cmd.ready is high whenever the
//  sequencer is idle, even while a finished level still waits in the
//  output register.
// Reset: the table reads as the identity levels until the first rescale;
//  no clearing pass is needed. Registers take their reset values.
// Stall: a held output keeps the next result in the sequencer until taken.
// ----------------------------------------------------------------------------
module dual_band_scan_threshold_engine import dbst_pkg::*; #(
  parameter int RANGE_LOW_DBM  = -105,
  parameter int RANGE_HIGH_DBM = -45,
  parameter int INVALID_LEVEL  = -127
) (
  input  logic              clk,
  input  logic              rst,
  dbst_cmd_if.sink          cmd,
  dbst_lvl_if.source        level,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int SPAN_RAW  = RANGE_HIGH_DBM - RANGE_LOW_DBM + 1;
  localparam int DEPTH     = (SPAN_RAW > 0) ? SPAN_RAW : 0;
  localparam int MEM_D     = (DEPTH > 0) ? DEPTH : 1;
  localparam int IDX_W     = (MEM_D > 1) ? $clog2(MEM_D) : 1;
  localparam int CNT_W     = $clog2(MEM_D + 1);
  localparam bit HAS_TABLE = DEPTH > 0;

  localparam logic signed [EXT_W-1:0] LOW_L  = EXT_W'(RANGE_LOW_DBM);
  localparam logic signed [EXT_W-1:0] HIGH_L = EXT_W'(RANGE_HIGH_DBM);
  localparam logic signed [EXT_W-1:0] INV_L  = EXT_W'(INVALID_LEVEL);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DEC  = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_LD   = 8'b0000_1000,
    S_MD   = 8'b0001_0000,
    S_TR   = 8'b0010_0000,
    S_TW   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } seq_state_t;

  cfg_t       cfg;
  md_req_t    md_req;
  md_rsp_t    md_rsp;
  seq_state_t state;
  logic       loaded;
  logic       out_valid;
  logic       out_load;

  // Held request
  logic                    act;
  logic signed [LVL_W-1:0] sw;
  logic signed [LVL_W-1:0] trig;
  logic signed [LVL_W-1:0] r24;
  logic signed [LVL_W-1:0] r5;

  logic [CNT_W-1:0]        cnt;
  logic signed [ENT_W-1:0] result;
  logic signed [ENT_W-1:0] out_data;
  logic                    q_neg;

  // Table memory
  logic signed [ENT_W-1:0] mem [MEM_D];
  logic signed [ENT_W-1:0] rd_data;
  logic [IDX_W-1:0]        rd_idx;
  logic                    mem_we;
  logic signed [ENT_W-1:0] mem_wdata;

  dbst_cfg_regs #(
    .INVALID_LEVEL (INVALID_LEVEL)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dbst_serial_md u_md (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // Widened levels
  logic signed [EXT_W-1:0] sw_x, trig_x, r24_x, r5_x;
  logic signed [EXT_W-1:0] p24_x, pp24_x, p5_x, o5_x, pscan_x, least_x;

  assign sw_x    = {{(EXT_W-LVL_W){sw[LVL_W-1]}}, sw};
  assign trig_x  = {{(EXT_W-LVL_W){trig[LVL_W-1]}}, trig};
  assign r24_x   = {{(EXT_W-LVL_W){r24[LVL_W-1]}}, r24};
  assign r5_x    = {{(EXT_W-LVL_W){r5[LVL_W-1]}}, r5};
  assign p24_x   = {{(EXT_W-LVL_W){cfg.peak_24g[LVL_W-1]}}, cfg.peak_24g};
  assign pp24_x  = {{(EXT_W-LVL_W){cfg.partner_24g[LVL_W-1]}}, cfg.partner_24g};
  assign p5_x    = {{(EXT_W-LVL_W){cfg.peak_5g[LVL_W-1]}}, cfg.peak_5g};
  assign o5_x    = {{(EXT_W-LVL_W){cfg.own_5g[LVL_W-1]}}, cfg.own_5g};
  assign pscan_x = {{(EXT_W-LVL_W){cfg.peak_scan[LVL_W-1]}}, cfg.peak_scan};
  assign least_x = {{(EXT_W-LVL_W){cfg.least_tgt[LVL_W-1]}}, cfg.least_tgt};

  // Adjacency of the two access points
  logic signed [EXT_W-1:0] gap24, gap5;
  logic ok24, ok5, v5, adj;

  assign gap24 = p24_x - pp24_x;
  assign gap5  = p5_x - o5_x;
  assign ok24  = (gap24 >= -ADJ_GAP) && (gap24 <= ADJ_GAP);
  assign ok5   = (gap5 >= -ADJ_GAP) && (gap5 <= ADJ_GAP);
  assign v5    = (p5_x != INV_L) && (o5_x != INV_L);
  assign adj   = ok24 && (!v5 || ok5);

  // Query level without the table
  logic signed [EXT_W-1:0] dlt, dlt_cl, cand, qmin, qlvl;
  logic                    scan_ok;

  assign dlt     = sw_x - least_x;
  assign scan_ok = (pscan_x != INV_L) && (least_x != INV_L);

  always_comb begin
    if (dlt < -DELTA_LIM)     dlt_cl = -EXT_W'(DELTA_LIM);
    else if (dlt > DELTA_LIM) dlt_cl = EXT_W'(DELTA_LIM);
    else                      dlt_cl = dlt;
    cand = pscan_x - dlt_cl;
    qmin = (p24_x < cand) ? p24_x : cand;
    if (adj)          qlvl = sw_x - EXT_W'(ADJ_STEP);
    else if (scan_ok) qlvl = qmin;
    else              qlvl = p24_x;
  end

  // Stepped trigger level, rescale span and divisor
  logic signed [NT_W-1:0] sw_w, trig_w, high_w, nt_up, nt, span, den;
  logic [SPAN_W-1:0]      span_mag;
  logic [DEN_W-1:0]       den_mag;

  assign sw_w   = {{(NT_W-LVL_W){sw[LVL_W-1]}}, sw};
  assign trig_w = {{(NT_W-LVL_W){trig[LVL_W-1]}}, trig};
  assign high_w = {HIGH_L[EXT_W-1], HIGH_L};
  assign nt_up  = trig_w + NT_W'(TRIG_STEP);

  always_comb begin
    if (r5_x < sw_x)
      nt = (nt_up > high_w) ? high_w : nt_up;
    else if ((r5_x > sw_x + EXT_W'(TRIG_OVF)) && (r24_x < trig_x + EXT_W'(TRIG_OVF)))
      nt = trig_w - NT_W'(TRIG_STEP);
    else
      nt = trig_w;
  end

  assign span     = high_w - nt;
  assign den      = high_w - sw_w;
  assign span_mag = span[NT_W-1] ? SPAN_W'(-span) : SPAN_W'(span);
  assign den_mag  = den[NT_W-1] ? DEN_W'(-den) : DEN_W'(den);

  // Table addressing
  logic             in_range;
  logic [IDX_W-1:0] tbl_idx;
  logic [IDX_W-1:0] ent_idx;

  assign in_range = (sw_x >= LOW_L) && (sw_x <= HIGH_L);
  assign tbl_idx  = IDX_W'(sw_x - LOW_L);
  assign ent_idx  = cnt[IDX_W-1:0];
  assign rd_idx   = (state == S_TR) ? tbl_idx : ent_idx;

  // Entry under rescale: identity level until the first full sweep
  logic signed [ENT_W-1:0] ent_init, entry;
  logic signed [ENT_W:0]   diff;
  logic [MAG_W-1:0]        diff_mag;

  assign ent_init = {{(ENT_W-EXT_W){LOW_L[EXT_W-1]}}, LOW_L} + ENT_W'(cnt);
  assign entry    = loaded ? rd_data : ent_init;
  assign diff     = {entry[ENT_W-1], entry} - {{(ENT_W+1-LVL_W){sw[LVL_W-1]}}, sw};
  assign diff_mag = diff[ENT_W] ? MAG_W'(-diff) : MAG_W'(diff);

  assign md_req.start   = (state == S_LD);
  assign md_req.mcand   = diff_mag;
  assign md_req.mplier  = span_mag;
  assign md_req.divisor = den_mag;

  // Signed quotient plus new trigger, saturated to the entry width
  localparam int SUM_W = PROD_W + 2;
  logic signed [SUM_W-1:0] q_s, v_s;

  assign q_s = q_neg ? -{2'b00, md_rsp.quot} : {2'b00, md_rsp.quot};
  assign v_s = q_s + {{(SUM_W-NT_W){nt[NT_W-1]}}, nt};

  always_comb begin
    if (v_s > SUM_W'(32767))       mem_wdata = 16'sh7FFF;
    else if (v_s < -SUM_W'(32768)) mem_wdata = 16'sh8000;
    else                           mem_wdata = v_s[ENT_W-1:0];
  end

  assign mem_we = (state == S_MD) && md_rsp.done;

  // Table storage with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[ent_idx] <= mem_wdata;
    rd_data <= mem[rd_idx];
  end

  assign out_load  = (state == S_DONE) && (!out_valid || level.ready);
  assign cmd.ready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      loaded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load)                       out_valid <= 1'b1;
      else if (out_valid && level.ready)  out_valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd.valid) state <= S_DEC;
        S_DEC: begin
          if (act == ACT_UPDATE) begin
            if ((r24_x < LOW_L) || (sw_x == HIGH_L))  state <= S_DONE;
            else if (cfg.same_router && HAS_TABLE)    state <= S_RD;
            else                                      state <= S_DONE;
          end else begin
            state <= (cfg.same_router && adj) ? S_TR : S_DONE;
          end
        end
        S_RD: state <= S_LD;
        S_LD: state <= S_MD;
        S_MD: begin
          if (md_rsp.done) begin
            if (cnt == CNT_W'(MEM_D - 1)) begin
              loaded <= 1'b1;
              state  <= S_TR;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_TR:   state <= in_range ? S_TW : S_DONE;
        S_TW:   state <= S_DONE;
        S_DONE: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request capture, sweep counter and result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        act  <= cmd.action;
        sw   <= cmd.switch_level;
        trig <= cmd.trigger_level;
        r24  <= cmd.rssi_24g_now;
        r5   <= cmd.rssi_5g_now;
      end
      S_DEC: begin
        cnt <= '0;
        if (act == ACT_UPDATE) begin
          if ((r24_x < LOW_L) || (sw_x == HIGH_L))
            result <= {{(ENT_W-LVL_W){trig[LVL_W-1]}}, trig};
          else
            result <= '0;
        end else begin
          result <= {{(ENT_W-EXT_W){qlvl[EXT_W-1]}}, qlvl};
        end
      end
      S_LD: q_neg <= diff[ENT_W] ^ span[NT_W-1] ^ den[NT_W-1];
      S_MD: if (md_rsp.done) cnt <= cnt + 1'b1;
      S_TR: result <= '0;
      S_TW: result <= loaded ? rd_data : {{(ENT_W-LVL_W){sw[LVL_W-1]}}, sw};
      default: ;
    endcase
    if (out_load) out_data <= result;
  end

  assign level.valid      = out_valid;
  assign level.scan_level = out_data;

endmodule
`default_nettype wire

// ===== hw/rtl/dbst_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-band scan threshold engine: port checker
// Watches the request, level and configuration ports of the top level.
// ----------------------------------------------------------------------------
module dbst_checker import dbst_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              lvl_valid,
  input logic              lvl_ready,
  input logic [ENT_W-1:0]  lvl_scan,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [CFG_AW-1:0] paddr,
  input logic [APB_DW-1:0] pwdata,
  input logic [APB_DW-1:0] prdata
);

  logic wr_peak;

  assign wr_peak = psel && penable && pwrite && (paddr[4:2] == REG_PEAK_24G);

  // One request at a time: ready drops after each accepted request
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("request accepted while another is in flight");

  // A new level appears only after the sequencer has left idle
  a_level_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(lvl_valid) |-> !$past(cmd_ready))
    else $error("level produced without a request in flight");

  // A stalled level holds
  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    lvl_valid && !lvl_ready |=> lvl_valid && $stable(lvl_scan))
    else $error("stalled level changed or dropped");

  // A write to the 2.4 GHz peak register reads back while the address is held
  a_reg_readback: assert property (@(posedge clk) disable iff (rst)
    wr_peak |=> (paddr != $past(paddr)) || (prdata[7:0] == $past(pwdata[7:0])))
    else $error("register read back differs from write");

  // Reset leaves the block idle with no level pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !lvl_valid && cmd_ready)
    else $error("block not idle after reset");

endmodule

bind dual_band_scan_threshold_engine dbst_checker u_dbst_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .lvl_valid (level.valid),
  .lvl_ready (level.ready),
  .lvl_scan  (level.scan_level),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
`default_nettype wire

// ===== verif/dual_band_scan_threshold_engine_test.sv =====
// ----------------------------------------------------------------------------
// Dual-band scan threshold engine: block-level testbench
// Drives query and update requests on the request channel and programmes the
// learned RSSI registers over APB while the engine is idle. Every scan level
// is checked against a pinned level or a local predictor with its own copy
// of the threshold table. A short scripted run covers reset behaviour, range
// edges, early exits and saturation. Random phases with varied register
// settings, random gaps on both channels and one long output stall follow.
// ----------------------------------------------------------------------------
module dual_band_scan_threshold_engine_test import dbst_pkg::*;;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int TIMEOUT_CYCLES = 4_000_000;
  localparam int LOW_DBM        = -105;
  localparam int HIGH_DBM       = -45;
  localparam int INVALID_DBM    = -127;
  localparam int TABLE_DEPTH    = HIGH_DBM - LOW_DBM + 1;
  localparam int LVL_MIN        = -(2 ** (LVL_W - 1));
  localparam int LVL_MAX        = 2 ** (LVL_W - 1) - 1;
  localparam int ENT_MIN        = -(2 ** (ENT_W - 1));
  localparam int ENT_MAX        = 2 ** (ENT_W - 1) - 1;
  localparam int N_DIRECTED     = 33;
  localparam int N_PHASES       = 12;
  localparam int PHASE_ITEMS    = 36;
  localparam int LONG_HOLD      = 150;
  localparam int SETTLE_CYCLES  = 20;

  // One request as offered on the channel, with an optional hand-typed level
  typedef struct packed {
    action_t                 act;
    logic signed [LVL_W-1:0] sw;
    logic signed [LVL_W-1:0] trig;
    logic signed [LVL_W-1:0] r24;
    logic signed [LVL_W-1:0] r5;
    logic                    pinned;
    logic signed [ENT_W-1:0] pinned_level;
  } lvl_request_t;

  // One line of the scripted run: a register write or a request
  typedef struct packed {
    bit       is_cfg;
    reg_idx_t reg_sel;
    int       cfg_val;
    action_t  act;
    int       sw;
    int       trig;
    int       r24;
    int       r5;
    bit       pinned;
    int       pinned_level;
  } script_row_t;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  dbst_cmd_if req_ch ();
  dbst_lvl_if lvl_ch ();

  lvl_request_t offered = '0;

  // Predictor state: register copy and threshold table
  cfg_t                    router_cfg;
  logic signed [ENT_W-1:0] level_table [TABLE_DEPTH];
  logic signed [ENT_W-1:0] pending_levels [$];

  bit steady       = 1'b0;
  bit hold_request = 1'b0;
  int fail_count    = 0;
  int query_count   = 0;
  int update_count  = 0;
  int rescale_count = 0;
  int levels_seen   = 0;
  int setting_count = 0;

  assign req_ch.action        = offered.act;
  assign req_ch.switch_level  = offered.sw;
  assign req_ch.trigger_level = offered.trig;
  assign req_ch.rssi_24g_now  = offered.r24;
  assign req_ch.rssi_5g_now   = offered.r5;

  dual_band_scan_threshold_engine #(
    .RANGE_LOW_DBM  (LOW_DBM),
    .RANGE_HIGH_DBM (HIGH_DBM),
    .INVALID_LEVEL  (INVALID_DBM)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .cmd     (req_ch),
    .level   (lvl_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_level(int v);
    if (v < LVL_MIN) return LVL_MIN;
    if (v > LVL_MAX) return LVL_MAX;
    return v;
  endfunction

  // Mostly back to back, sometimes short gaps, rarely long ones
  function automatic int idle_cycles();
    int k;
    k = int'($urandom_range(99));
    if (k < 55) return 0;
    if (k < 85) return pick(1, 3);
    if (k < 97) return pick(4, 12);
    return pick(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Scan level predictor
  // ---------------------------------------------------------------------------
  function automatic int band_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit bands_adjacent();
    bit ok;
    ok = band_gap(router_cfg.peak_24g, router_cfg.partner_24g) <= ADJ_GAP;
    if (router_cfg.peak_5g != INVALID_DBM && router_cfg.own_5g != INVALID_DBM)
      ok = ok && (band_gap(router_cfg.peak_5g, router_cfg.own_5g) <= ADJ_GAP);
    return ok;
  endfunction

  function automatic int table_entry(int sw);
    if (sw < LOW_DBM || sw > HIGH_DBM || !router_cfg.same_router) return 0;
    return level_table[sw - LOW_DBM];
  endfunction

  function automatic int query_level(int sw);
    int d;
    int c;
    if (router_cfg.same_router && bands_adjacent()) return table_entry(sw);
    if (bands_adjacent()) return sw - ADJ_STEP;
    if (router_cfg.peak_scan != INVALID_DBM && router_cfg.least_tgt != INVALID_DBM) begin
      d = sw - router_cfg.least_tgt;
      if (d < -DELTA_LIM) d = -DELTA_LIM;
      else if (d > DELTA_LIM) d = DELTA_LIM;
      c = router_cfg.peak_scan - d;
      return (router_cfg.peak_24g < c) ? int'(router_cfg.peak_24g) : c;
    end
    return router_cfg.peak_24g;
  endfunction

  // Step the trigger, rescale every entry (truncating division), answer entry
  function automatic int update_level(int trig, int sw, int r24, int r5);
    int     nt;
    longint span;
    longint den;
    longint v;
    nt = trig;
    if (r24 < LOW_DBM) return trig;
    if (r5 < sw) begin
      nt = nt + TRIG_STEP;
      if (nt > HIGH_DBM) nt = HIGH_DBM;
    end else if (r5 > sw + TRIG_OVF && r24 < trig + TRIG_OVF) begin
      nt = nt - TRIG_STEP;
    end
    if (sw == HIGH_DBM) return trig;
    if (router_cfg.same_router) begin
      rescale_count++;
      span = longint'(HIGH_DBM - nt);
      den  = longint'(HIGH_DBM - sw);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        v = (span * (longint'(level_table[i]) - sw)) / den + nt;
        if (v > ENT_MAX) v = ENT_MAX;
        if (v < ENT_MIN) v = ENT_MIN;
        level_table[i] = v[ENT_W-1:0];
      end
    end
    return table_entry(sw);
  endfunction

  // ---------------------------------------------------------------------------
  // Scripted rows
  // ---------------------------------------------------------------------------
  function automatic script_row_t cfg_row(reg_idx_t idx, int value);
    script_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_sel = idx;
    r.cfg_val = value;
    return r;
  endfunction

  function automatic script_row_t pred_row(action_t act, int sw, int trig, int r24, int r5);
    script_row_t r;
    r = '0;
    r.act  = act;
    r.sw   = sw;
    r.trig = trig;
    r.r24  = r24;
    r.r5   = r5;
    return r;
  endfunction

  function automatic script_row_t known_row(action_t act, int sw, int trig, int r24, int r5,
                                            int lvl);
    script_row_t r;
    r = pred_row(act, sw, trig, r24, r5);
    r.pinned       = 1'b1;
    r.pinned_level = lvl;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver and APB access
  // ---------------------------------------------------------------------------
  // Enter and leave at a falling edge; keep valid high when no gap is drawn
  task automatic offer_request(input lvl_request_t r);
    int idle;
    idle = steady ? 0 : idle_cycles();
    if (idle > 0) begin
      req_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    offered      <= r;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every scan level owed has come back
  task automatic drain_levels();
    req_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
  endtask

  // Write one register, mirror it in the predictor, then read it back
  task automatic write_register(input reg_idx_t idx, input int value);
    logic [APB_DW-1:0] mask;
    logic [APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SAME_ROUTER: router_cfg.same_router = value[0];
      REG_PEAK_24G:    router_cfg.peak_24g    = value[LVL_W-1:0];
      REG_PARTNER_24G: router_cfg.partner_24g = value[LVL_W-1:0];
      REG_PEAK_5G:     router_cfg.peak_5g     = value[LVL_W-1:0];
      REG_OWN_5G:      router_cfg.own_5g      = value[LVL_W-1:0];
      REG_PEAK_SCAN:   router_cfg.peak_scan   = value[LVL_W-1:0];
      REG_LEAST_TGT:   router_cfg.least_tgt   = value[LVL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    // Leave the bus idle before the next access
    @(negedge clk);
    mask = (idx == REG_SAME_ROUTER) ? APB_DW'(1) : APB_DW'((1 << LVL_W) - 1);
    if ((rd & mask) !== (APB_DW'(value) & mask)) begin
      $error("prdata[%s]: expected %0h, got %0h", idx.name(), APB_DW'(value) & mask,
             rd & mask);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checker: retire levels, then predict for each accepted request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : level_check
    logic signed [ENT_W-1:0] want;
    int                      predicted;
    if (!rst) begin
      if (lvl_ch.valid && lvl_ch.ready) begin
        levels_seen++;
        if (pending_levels.size() == 0) begin
          $error("scan_level: expected none, got %0d", lvl_ch.scan_level);
          fail_count++;
        end else begin
          want = pending_levels.pop_front();
          if (lvl_ch.scan_level !== want) begin
            $error("scan_level: expected %0d, got %0d", want, lvl_ch.scan_level);
            fail_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.action == ACT_UPDATE) begin
          update_count++;
          predicted = update_level(int'(req_ch.trigger_level), int'(req_ch.switch_level),
                                   int'(req_ch.rssi_24g_now), int'(req_ch.rssi_5g_now));
        end else begin
          query_count++;
          predicted = query_level(int'(req_ch.switch_level));
        end
        want = offered.pinned ? offered.pinned_level : ENT_W'(predicted);
        pending_levels = {pending_levels, want};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : level_sink
    int stall_left;
    stall_left   = 0;
    lvl_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (rst || stall_left > 0) begin
        lvl_ch.ready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        lvl_ch.ready <= 1'b1;
        if (!steady && $urandom_range(99) < 30) stall_left = idle_cycles();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    script_row_t directed_rows [N_DIRECTED];
    lvl_request_t rq;
    int sr, p24, pa24, p5, o5, scan, tgt;
    int sw, k;

    req_ch.valid = 1'b0;

    // Predictor reset: identity table, router flag clear, levels invalid
    router_cfg.same_router = 1'b0;
    router_cfg.peak_24g    = LVL_W'(INVALID_DBM);
    router_cfg.partner_24g = LVL_W'(INVALID_DBM);
    router_cfg.peak_5g     = LVL_W'(INVALID_DBM);
    router_cfg.own_5g      = LVL_W'(INVALID_DBM);
    router_cfg.peak_scan   = LVL_W'(INVALID_DBM);
    router_cfg.least_tgt   = LVL_W'(INVALID_DBM);
    for (int i = 0; i < TABLE_DEPTH; i++) level_table[i] = ENT_W'(LOW_DBM + i);

    directed_rows = '{
      // reset settings: adjacent, no table
      known_row(ACT_QUERY,  -128,    0,    0,    0, -133),
      known_row(ACT_QUERY,   127,    0,    0,    0,  122),
      known_row(ACT_UPDATE,  -80,  -90, -110,    0,  -90),   // weak 2.4 GHz signal
      known_row(ACT_UPDATE,  -45,  127,    0,    0,  127),   // switch at top of range
      known_row(ACT_UPDATE,  -80,  -70,  -60,  -60,    0),   // table absent
      cfg_row(REG_SAME_ROUTER, 1),
      known_row(ACT_QUERY,  -105,    0,    0,    0, -105),
      known_row(ACT_QUERY,   -45,    0,    0,    0,  -45),
      known_row(ACT_QUERY,  -106,    0,    0,    0,    0),   // below range
      known_row(ACT_QUERY,   -44,    0,    0,    0,    0),   // above range
      pred_row(ACT_UPDATE,   -75,  -80,  -70,  -90),         // step trigger up
      pred_row(ACT_QUERY,    -75,    0,    0,    0),
      pred_row(ACT_UPDATE,   -46, -128, -100,  -40),         // divisor of one
      pred_row(ACT_UPDATE,   -46, -128, -100,  -40),         // entries saturate
      pred_row(ACT_QUERY,   -100,    0,    0,    0),
      pred_row(ACT_UPDATE,   127,  127,  127,  127),
      pred_row(ACT_UPDATE,  -128,  127, -100, -100),         // step trigger down
      pred_row(ACT_UPDATE,     0,  -48,  -50,  -10),         // clamp at top, zero span
      cfg_row(REG_PEAK_24G, -40),
      cfg_row(REG_PARTNER_24G, -70),
      known_row(ACT_QUERY,   -60,    0,    0,    0,  -40),   // not adjacent, no scan data
      cfg_row(REG_PEAK_SCAN, -50),
      cfg_row(REG_LEAST_TGT, -80),
      pred_row(ACT_QUERY,   -128,    0,    0,    0),         // delta clamped low
      pred_row(ACT_QUERY,    127,    0,    0,    0),         // delta clamped high
      cfg_row(REG_PARTNER_24G, -35),
      cfg_row(REG_PEAK_5G, -60),
      cfg_row(REG_OWN_5G, -80),
      pred_row(ACT_QUERY,    -70,    0,    0,    0),         // 5 GHz gap too wide
      cfg_row(REG_OWN_5G, INVALID_DBM),
      pred_row(ACT_QUERY,    -60,    0,    0,    0),
      cfg_row(REG_SAME_ROUTER, 0),
      known_row(ACT_QUERY,   -60,    0,    0,    0,  -65)
    };

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Scripted part
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].is_cfg) begin
        drain_levels();
        write_register(directed_rows[i].reg_sel, directed_rows[i].cfg_val);
      end else begin
        rq.act          = directed_rows[i].act;
        rq.sw           = LVL_W'(directed_rows[i].sw);
        rq.trig         = LVL_W'(directed_rows[i].trig);
        rq.r24          = LVL_W'(directed_rows[i].r24);
        rq.r5           = LVL_W'(directed_rows[i].r5);
        rq.pinned       = directed_rows[i].pinned;
        rq.pinned_level = ENT_W'(directed_rows[i].pinned_level);
        offer_request(rq);
      end
    end

    // Random phases, each under fresh register settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_levels();
      if (ph == 0) begin
        sr = 1; p24 = LVL_MAX; pa24 = LVL_MAX; p5 = LVL_MAX; o5 = LVL_MAX;
        scan = LVL_MAX; tgt = LVL_MAX;
      end else if (ph == 1) begin
        sr = 0; p24 = LVL_MIN; pa24 = LVL_MIN; p5 = LVL_MIN; o5 = LVL_MIN;
        scan = LVL_MIN; tgt = LVL_MIN;
      end else begin
        sr  = int'($urandom_range(1));
        p24 = ($urandom_range(99) < 15) ? pick(LVL_MIN, LVL_MAX) : pick(-100, -30);
        case ($urandom_range(2))
          0: pa24 = clamp_level(p24 + pick(-ADJ_GAP, ADJ_GAP));
          1: pa24 = clamp_level(($urandom_range(1) != 0) ? p24 + pick(ADJ_GAP + 1, 60)
                                                          : p24 - pick(ADJ_GAP + 1, 60));
          default: pa24 = pick(LVL_MIN, LVL_MAX);
        endcase
        p5 = ($urandom_range(99) < 25) ? INVALID_DBM : pick(-100, -30);
        case ($urandom_range(3))
          0: o5 = INVALID_DBM;
          1: o5 = clamp_level(p5 + pick(-ADJ_GAP, ADJ_GAP));
          2: o5 = clamp_level(p5 - pick(ADJ_GAP + 1, 60));
          default: o5 = pick(LVL_MIN, LVL_MAX);
        endcase
        scan = ($urandom_range(99) < 25) ? INVALID_DBM : pick(-95, -30);
        tgt  = ($urandom_range(99) < 25) ? INVALID_DBM : pick(LVL_MIN, LVL_MAX);
      end
      write_register(REG_SAME_ROUTER, sr);
      write_register(REG_PEAK_24G, p24);
      write_register(REG_PARTNER_24G, pa24);
      write_register(REG_PEAK_5G, p5);
      write_register(REG_OWN_5G, o5);
      write_register(REG_PEAK_SCAN, scan);
      write_register(REG_LEAST_TGT, tgt);
      setting_count++;

      // every third phase runs without gaps; the fast phase fills the engine
      steady = (ph % 3 == 2);
      if (ph == 1) hold_request = 1'b1;

      repeat (PHASE_ITEMS) begin
        rq.act = ($urandom_range(99) < 25) ? ACT_UPDATE : ACT_QUERY;
        k = int'($urandom_range(99));
        if (k < 10) begin
          sw = HIGH_DBM;
        end else if (k < 20) begin
          case ($urandom_range(4))
            0: sw = LOW_DBM;
            1: sw = LOW_DBM - 1;
            2: sw = HIGH_DBM + 1;
            3: sw = LVL_MIN;
            default: sw = LVL_MAX;
          endcase
        end else if (k < 35) begin
          sw = pick(LVL_MIN, LVL_MAX);
        end else begin
          sw = pick(LOW_DBM - 5, HIGH_DBM + 5);
        end
        rq.sw   = LVL_W'(sw);
        rq.trig = LVL_W'(($urandom_range(99) < 20) ? pick(LVL_MIN, LVL_MAX) : pick(-100, -40));
        k = int'($urandom_range(99));
        if (k < 12) rq.r24 = LVL_W'(pick(LVL_MIN, LOW_DBM - 1));
        else if (k < 25) rq.r24 = LVL_W'(pick(LVL_MIN, LVL_MAX));
        else rq.r24 = LVL_W'(pick(LOW_DBM, -20));
        case ($urandom_range(3))
          0: rq.r5 = LVL_W'(clamp_level(sw - pick(1, 20)));
          1: rq.r5 = LVL_W'(clamp_level(sw + pick(0, TRIG_OVF)));
          2: rq.r5 = LVL_W'(clamp_level(sw + pick(TRIG_OVF + 1, 40)));
          default: rq.r5 = LVL_W'(pick(LVL_MIN, LVL_MAX));
        endcase
        rq.pinned       = 1'b0;
        rq.pinned_level = '0;
        offer_request(rq);
      end
    end

    // Drain, then let the settle time pass to catch stray levels
    steady = 1'b0;
    drain_levels();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d queries and %0d updates (%0d rescaled the table) under %0d settings.",
             query_count, update_count, rescale_count, setting_count + 1);
    $display("Checked %0d scan levels, one long output stall of %0d cycles, %0d errors.",
             levels_seen, LONG_HOLD, fail_count);
    if (fail_count == 0 && pending_levels.size() == 0) begin
      $display("** dual_band_scan_threshold_engine: PASSED **");
    end else begin
      $display("** dual_band_scan_threshold_engine: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("** dual_band_scan_threshold_engine: FAILED **");
    $finish;
  end

endmodule
